>>> rtl/core/fssc_pkg.sv
// fssc_pkg: shared types, codes and constants of the fan start/stop calibrator
// no dependencies; used by every module of the block
package fssc_pkg;

    // command codes carried in func
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_ABORT = 2'd2;

    // calibration phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_START = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // duty constants
    localparam logic [7:0] DUTY_FULL   = 8'd255;
    localparam logic [7:0] DUTY_DROP   = 8'd5;
    localparam logic [7:0] DUTY_RAISE  = 8'd2;
    localparam logic [7:0] STOP_MARGIN = 8'd5;

    // register file
    localparam int          APB_ADDR_W    = 3;
    localparam int          APB_DATA_W    = 32;
    localparam logic        REG_LIMIT_SEL = 1'b0;
    localparam logic [7:0]  LIMIT_RESET   = 8'd10;

    // reciprocal of 20 in 16 fractional bits, exact for operands below 16384
    localparam logic [11:0] RECIP20   = 12'd3277;
    localparam int          RECIP20_Q = 16;

    typedef struct packed {
        logic [1:0] phase;
        logic       busy;
        logic [7:0] duty;
        logic [7:0] zero_cnt;
        logic       mode;
        logic [7:0] min_start;
        logic [7:0] min_stop;
        logic       long_wait;
    } cal_state_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       duty_written;
        logic       pwm_mode_on;
        logic       busy_res;
        logic [1:0] phase;
        logic [7:0] min_start;
        logic       min_start_set;
        logic [7:0] min_stop;
        logic       min_stop_set;
        logic       long_wait;
    } cal_result_t;

    // floor(d*19/20) written as d - ceil(d/20)
    function automatic logic [7:0] duty_scale_down(input logic [7:0] d);
        logic [8:0]  num;
        logic [23:0] prod;
        logic [7:0]  q;
        num  = 9'(d) + 9'd19;
        prod = 24'(num) * 24'(RECIP20);
        q    = prod[RECIP20_Q +: 8];
        return d - q;
    endfunction

endpackage

>>> rtl/core/fssc_ifs.sv
// fssc_ifs: valid/ready channel interfaces for command and result transactions
// no dependencies; the result fields mirror cal_result_t of fssc_pkg
interface fssc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] fan_speed;

    modport source (output valid, output func, output fan_speed, input ready);
    modport sink   (input valid, input func, input fan_speed, output ready);
endinterface

interface fssc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       duty_written;
    logic       pwm_mode_on;
    logic       busy_res;
    logic [1:0] phase;
    logic [7:0] min_start;
    logic       min_start_set;
    logic [7:0] min_stop;
    logic       min_stop_set;
    logic       long_wait;

    modport source (output valid, output duty, output duty_written, output pwm_mode_on,
                    output busy_res, output phase, output min_start, output min_start_set,
                    output min_stop, output min_stop_set, output long_wait, input ready);
    modport sink   (input valid, input duty, input duty_written, input pwm_mode_on,
                    input busy_res, input phase, input min_start, input min_start_set,
                    input min_stop, input min_stop_set, input long_wait, output ready);
endinterface

>>> rtl/core/fssc_apb_regs.sv
// fssc_apb_regs: APB register file holding the zero-speed tolerance
// depends on fssc_pkg for address width and reset value
module fssc_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fssc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fssc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fssc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [7:0]                      zero_speed_limit
);
    import fssc_pkg::*;

    logic [7:0] limit_reg;
    logic [7:0] limit_next;
    logic       wr_en;

    // write strobe at the access phase
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_LIMIT_SEL);
    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en)
        begin
            limit_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LIMIT_SEL)
        begin
            prdata = {{(APB_DATA_W-8){1'b0}}, limit_reg};
        end
    end

    assign zero_speed_limit = limit_reg;
endmodule

>>> rtl/core/fssc_step.sv
// fssc_step: one calibration step, next state and result from current state
// depends on fssc_pkg for state/result structs, codes and the duty scaling function
module fssc_step (
    input  fssc_pkg::cal_state_t  cur,
    input  logic [1:0]            func,
    input  logic                  spinning,
    input  logic [7:0]            zero_speed_limit,
    output fssc_pkg::cal_state_t  nxt,
    output fssc_pkg::cal_result_t res
);
    import fssc_pkg::*;

    logic [7:0] d;
    logic [7:0] down_a;
    logic [7:0] down_b;
    logic [7:0] nv;
    logic       drive;
    logic       zero_done;
    logic [7:0] zero_cnt_tick;
    logic       start_set;
    logic       stop_set;

    assign d = cur.duty;

    // phase 1 candidates
    assign down_a = duty_scale_down(d);
    assign down_b = (d >= DUTY_DROP) ? (d - DUTY_DROP) : 8'd0;

    // zero-speed tolerance counter
    always_comb
    begin
        if (cur.zero_cnt < zero_speed_limit)
        begin
            zero_cnt_tick = cur.zero_cnt + 8'd1;
            zero_done     = 1'b0;
        end
        else
        begin
            zero_cnt_tick = 8'd0;
            zero_done     = 1'b1;
        end
    end

    // step decision
    always_comb
    begin
        nxt       = cur;
        drive     = 1'b0;
        nv        = d;
        start_set = 1'b0;
        stop_set  = 1'b0;
        if (func == FUNC_START)
        begin
            nxt.busy      = 1'b1;
            nxt.phase     = PH_FIRST;
            nxt.mode      = 1'b1;
            drive         = 1'b1;
            nv            = DUTY_FULL;
            nxt.long_wait = 1'b0;
        end
        else if (func == FUNC_ABORT)
        begin
            drive    = 1'b1;
            nv       = DUTY_FULL;
            nxt.busy = 1'b0;
        end
        else if (func == FUNC_TICK && cur.busy)
        begin
            unique case (cur.phase)
                PH_FIRST:
                begin
                    if (spinning)
                    begin
                        drive        = 1'b1;
                        nv           = (down_a < down_b) ? down_a : down_b;
                        nxt.zero_cnt = 8'd0;
                    end
                    else
                    begin
                        nxt.zero_cnt = zero_cnt_tick;
                        if (zero_done)
                        begin
                            nxt.phase     = PH_START;
                            nxt.long_wait = 1'b0;
                        end
                    end
                end
                PH_START:
                begin
                    if (!spinning)
                    begin
                        drive = 1'b1;
                        nv    = (d >= (DUTY_FULL - DUTY_RAISE)) ? DUTY_FULL : (d + DUTY_RAISE);
                    end
                    else
                    begin
                        nxt.phase     = PH_STOP;
                        nxt.long_wait = 1'b1;
                        nxt.min_start = d;
                        start_set     = 1'b1;
                    end
                end
                PH_STOP:
                begin
                    if (spinning)
                    begin
                        drive        = 1'b1;
                        nv           = (d != 8'd0) ? (d - 8'd1) : 8'd0;
                        nxt.zero_cnt = 8'd0;
                    end
                    else
                    begin
                        nxt.zero_cnt = zero_cnt_tick;
                        if (zero_done)
                        begin
                            nxt.phase    = PH_IDLE;
                            nxt.busy     = 1'b0;
                            nxt.min_stop = (d >= (DUTY_FULL - STOP_MARGIN)) ? DUTY_FULL
                                                                             : (d + STOP_MARGIN);
                            stop_set     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    nxt.busy = 1'b0;
                end
            endcase
        end
        if (drive)
        begin
            nxt.duty = nv;
        end
    end

    // result fields show the state after the step
    always_comb
    begin
        res.duty          = nxt.duty;
        res.duty_written  = drive && (nv != d);
        res.pwm_mode_on   = nxt.mode;
        res.busy_res      = nxt.busy;
        res.phase         = nxt.phase;
        res.min_start     = nxt.min_start;
        res.min_start_set = start_set;
        res.min_stop      = nxt.min_stop;
        res.min_stop_set  = stop_set;
        res.long_wait     = nxt.long_wait;
    end
endmodule

>>> rtl/core/fan_start_stop_calibrator.sv
// fan_start_stop_calibrator: top level, input register, state, step logic, result register
// depends on fssc_pkg, fssc_ifs, fssc_apb_regs and fssc_step
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------------
//  req      | in  | valid / ready  | func, fan_speed
//  rsp      | out | valid / ready  | duty, duty_written, pwm_mode_on, busy_res, phase,
//           |     |                | min_start(_set), min_stop(_set), long_wait
//  apb      | in  | psel / penable | zero_speed_limit at address 0, pready always high
//
// one result per command; an accepted command is held in the input register, then stepped
// into the result register where it is valid; one command per cycle sustained while rsp.ready
// holds; the step logic between the two registers is combinational and updates the state
// reset clears the state to idle with duty 255 and tolerance 10
// a stalled result holds the result register; the input register fills behind it
// and req.ready drops only when both are full
module fan_start_stop_calibrator (
    input  logic                            clk,
    input  logic                            rst_n,
    fssc_cmd_if.sink                        req,
    fssc_res_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fssc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fssc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fssc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fssc_pkg::*;

    logic [7:0]  zero_speed_limit;

    logic        in_valid_reg;
    logic [1:0]  in_func_reg;
    logic        in_spin_reg;
    logic        out_valid_reg;
    cal_result_t res_reg;
    cal_state_t  state_reg;
    cal_state_t  state_next;
    cal_result_t res_next;
    logic        advance;

    // configuration registers
    fssc_apb_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .zero_speed_limit (zero_speed_limit)
    );

    // handshake flow
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_func_reg <= req.func;
            in_spin_reg <= (req.fan_speed != 16'd0);
        end
    end

    // step logic
    fssc_step u_step (
        .cur              (state_reg),
        .func             (in_func_reg),
        .spinning         (in_spin_reg),
        .zero_speed_limit (zero_speed_limit),
        .nxt              (state_next),
        .res              (res_next)
    );

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.busy      <= 1'b0;
            state_reg.duty      <= DUTY_FULL;
            state_reg.zero_cnt  <= 8'd0;
            state_reg.mode      <= 1'b0;
            state_reg.min_start <= DUTY_FULL;
            state_reg.min_stop  <= DUTY_FULL;
            state_reg.long_wait <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.duty          = res_reg.duty;
    assign rsp.duty_written  = res_reg.duty_written;
    assign rsp.pwm_mode_on   = res_reg.pwm_mode_on;
    assign rsp.busy_res      = res_reg.busy_res;
    assign rsp.phase         = res_reg.phase;
    assign rsp.min_start     = res_reg.min_start;
    assign rsp.min_start_set = res_reg.min_start_set;
    assign rsp.min_stop      = res_reg.min_stop;
    assign rsp.min_stop_set  = res_reg.min_stop_set;
    assign rsp.long_wait     = res_reg.long_wait;

    // a running calibration always sits in one of the active phases
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy |-> (state_reg.phase != PH_IDLE))
        else $error("busy with idle phase");

    // recording the stop duty ends the run
    a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.min_stop_set) |-> (!res_reg.busy_res && res_reg.phase == PH_IDLE))
        else $error("min_stop recorded while still running");

    // state moves only with a transaction through the step logic
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

    // every stepped command produces a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step without result");
endmodule

>>> sim/fssc_calibration_checker.sv
// fssc_calibration_checker: predicts every calibration readout and compares it with the block
// depends on fssc_pkg for codes and the result struct, and on fssc_ifs for the channels
module fssc_calibration_checker #(
    parameter logic [fssc_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = '0
)(
    input  logic                            clk,
    input  logic                            rst_n,
    fssc_cmd_if                             req,
    fssc_res_if                             rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [fssc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fssc_pkg::APB_DATA_W-1:0] pwdata,
    output int                              mismatches,
    output int                              readouts_due,
    output int                              readouts_checked,
    output int                              starts_recorded,
    output int                              stops_recorded
);
    import fssc_pkg::*;

    // own copy of the tolerance register and the calibration state
    logic [7:0] tol_limit;
    logic [1:0] cal_phase;
    logic       cal_busy;
    logic [7:0] cal_duty;
    logic [7:0] zero_ticks;
    logic       pwm_on;
    logic [7:0] min_start_rec;
    logic [7:0] min_stop_rec;
    logic       slow_tick;

    cal_result_t readouts[$];
    int          faults;
    int          checked;
    int          starts;
    int          stops;

    // one calibration step; updates the state and returns the readout it produces
    function automatic cal_result_t calibration_step(input logic [1:0] f,
                                                     input logic [15:0] spd);
        cal_result_t r;
        logic        spinning;
        logic [7:0]  next_duty;
        int unsigned scaled;
        int unsigned lowered;
        r         = '0;
        spinning  = (spd != 16'd0);
        next_duty = cal_duty;
        case (f)
            FUNC_START:
            begin
                cal_busy  = 1'b1;
                cal_phase = PH_FIRST;
                pwm_on    = 1'b1;
                next_duty = DUTY_FULL;
                slow_tick = 1'b0;
            end
            FUNC_ABORT:
            begin
                next_duty = DUTY_FULL;
                cal_busy  = 1'b0;
            end
            FUNC_TICK:
            begin
                if (cal_busy)
                begin
                    case (cal_phase)
                        PH_FIRST:
                        begin
                            if (spinning)
                            begin
                                // smaller of 95 percent and duty less five
                                scaled    = (int'(cal_duty) * 19) / 20;
                                lowered   = (cal_duty >= DUTY_DROP) ? cal_duty - DUTY_DROP : 0;
                                next_duty = 8'((scaled < lowered) ? scaled : lowered);
                                zero_ticks = 8'd0;
                            end
                            else if (zero_ticks < tol_limit)
                                zero_ticks = zero_ticks + 8'd1;
                            else
                            begin
                                zero_ticks = 8'd0;
                                cal_phase  = PH_START;
                                slow_tick  = 1'b0;
                            end
                        end
                        PH_START:
                        begin
                            if (!spinning)
                                next_duty = (cal_duty >= 8'd253) ? DUTY_FULL
                                                                 : cal_duty + DUTY_RAISE;
                            else
                            begin
                                cal_phase       = PH_STOP;
                                slow_tick       = 1'b1;
                                min_start_rec   = cal_duty;
                                r.min_start_set = 1'b1;
                            end
                        end
                        PH_STOP:
                        begin
                            if (spinning)
                            begin
                                next_duty  = (cal_duty == 8'd0) ? 8'd0 : cal_duty - 8'd1;
                                zero_ticks = 8'd0;
                            end
                            else if (zero_ticks < tol_limit)
                                zero_ticks = zero_ticks + 8'd1;
                            else
                            begin
                                zero_ticks     = 8'd0;
                                cal_phase      = PH_IDLE;
                                cal_busy       = 1'b0;
                                min_stop_rec   = (cal_duty >= 8'd250) ? DUTY_FULL
                                                                      : cal_duty + STOP_MARGIN;
                                r.min_stop_set = 1'b1;
                            end
                        end
                        default:
                            cal_busy = 1'b0;
                    endcase
                end
            end
            default: ;
        endcase
        r.duty_written = (next_duty != cal_duty);
        cal_duty       = next_duty;
        r.duty         = cal_duty;
        r.pwm_mode_on  = pwm_on;
        r.busy_res     = cal_busy;
        r.phase        = cal_phase;
        r.min_start    = min_start_rec;
        r.min_stop     = min_stop_rec;
        r.long_wait    = slow_tick;
        return r;
    endfunction

    // compare one field and report any difference
    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want == got)
            return 1'b1;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        cal_result_t want;
        cal_result_t got;
        bit          ok;
        if (!rst_n)
        begin
            tol_limit     = LIMIT_RESET;
            cal_phase     = PH_IDLE;
            cal_busy      = 1'b0;
            cal_duty      = DUTY_FULL;
            zero_ticks    = 8'd0;
            pwm_on        = 1'b0;
            min_start_rec = DUTY_FULL;
            min_stop_rec  = DUTY_FULL;
            slow_tick     = 1'b0;
            readouts.delete();
            faults  = 0;
            checked = 0;
            starts  = 0;
            stops   = 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                tol_limit = pwdata[7:0];

            // result transaction against the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.duty, rsp.duty_written, rsp.pwm_mode_on, rsp.busy_res, rsp.phase,
                       rsp.min_start, rsp.min_start_set, rsp.min_stop, rsp.min_stop_set,
                       rsp.long_wait};
                if (readouts.size() == 0)
                begin
                    $display("%0t: readout expected none outstanding, got %h", $time, got);
                    faults++;
                end
                else
                begin
                    want = readouts.pop_front();
                    ok   = 1'b1;
                    ok  &= field_ok("duty", want.duty, got.duty);
                    ok  &= field_ok("duty_written", want.duty_written, got.duty_written);
                    ok  &= field_ok("pwm_mode_on", want.pwm_mode_on, got.pwm_mode_on);
                    ok  &= field_ok("busy_res", want.busy_res, got.busy_res);
                    ok  &= field_ok("phase", want.phase, got.phase);
                    ok  &= field_ok("min_start", want.min_start, got.min_start);
                    ok  &= field_ok("min_start_set", want.min_start_set, got.min_start_set);
                    ok  &= field_ok("min_stop", want.min_stop, got.min_stop);
                    ok  &= field_ok("min_stop_set", want.min_stop_set, got.min_stop_set);
                    ok  &= field_ok("long_wait", want.long_wait, got.long_wait);
                    if (!ok)
                        faults++;
                    checked++;
                end
            end

            // command transaction
            if (req.valid && req.ready)
            begin
                want = calibration_step(req.func, req.fan_speed);
                readouts.push_back(want);
                starts += want.min_start_set;
                stops  += want.min_stop_set;
            end
        end
        mismatches       <= faults;
        readouts_due     <= readouts.size();
        readouts_checked <= checked;
        starts_recorded  <= starts;
        stops_recorded   <= stops;
    end

endmodule

>>> sim/fan_start_stop_calibrator_tb.sv
// fan_start_stop_calibrator_tb: clock, reset, command and register stimulus, and the verdict
// depends on fssc_pkg, fssc_ifs, the calibrator and fssc_calibration_checker
module fan_start_stop_calibrator_tb;
    import fssc_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'({REG_LIMIT_SEL, 2'b00});
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT     = 300000;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam int         TOTAL_COMMANDS  = 1600;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fssc_cmd_if cmd_ch ();
    fssc_res_if res_ch ();

    int  tx_idle_pct;
    int  rx_idle_pct;
    int  commands_sent;
    int  cycle_count;
    int  random_limit;
    bit  hold_off_req;
    int  mismatches;
    int  readouts_due;
    int  readouts_checked;
    int  starts_recorded;
    int  stops_recorded;

    fan_start_stop_calibrator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cmd_ch),
        .rsp     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fssc_calibration_checker #(
        .LIMIT_ADDR (LIMIT_ADDR)
    ) u_readout_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (cmd_ch),
        .rsp              (res_ch),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatches       (mismatches),
        .readouts_due     (readouts_due),
        .readouts_checked (readouts_checked),
        .starts_recorded  (starts_recorded),
        .stops_recorded   (stops_recorded)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d readouts outstanding", cycle_count,
                 readouts_due);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
                @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] spin_speed();
        return 16'($urandom_range(1, 65535));
    endfunction

    // one command transaction, with random idle cycles ahead of it
    task automatic offer_cmd(input logic [1:0] f, input logic [15:0] s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.func      <= 2'($urandom());
            cmd_ch.fan_speed <= 16'($urandom());
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= f;
        cmd_ch.fan_speed <= s;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        commands_sent++;
    endtask

    // hold the sender until every readout is back
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (readouts_due == 0);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_limit(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {24'($urandom()), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one calibration run with random phase lengths; sometimes cut short or noisy
    task automatic run_sequence(input int lim, input bit clean);
        logic [15:0] speeds[$];
        int          spins;
        int          waits;
        int          cut;
        spins = $urandom_range(0, 55);
        for (int i = 0; i < spins; i++)
            speeds.push_back((!clean && $urandom_range(19) == 0) ? 16'd0 : spin_speed());
        for (int i = 0; i <= lim; i++)
            speeds.push_back(16'd0);
        waits = ($urandom_range(3) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 30);
        repeat (waits) speeds.push_back(16'd0);
        speeds.push_back(spin_speed());
        spins = $urandom_range(0, 70);
        for (int i = 0; i < spins; i++)
            speeds.push_back((!clean && $urandom_range(19) == 0) ? 16'd0 : spin_speed());
        for (int i = 0; i <= lim + 1; i++)
            speeds.push_back(16'd0);
        cut = (!clean && $urandom_range(99) < 15) ? $urandom_range(0, speeds.size() - 1) : -1;

        offer_cmd(FUNC_START, 16'($urandom()));
        foreach (speeds[i])
        begin
            if (i == cut)
            begin
                offer_cmd($urandom_range(1) ? FUNC_ABORT : FUNC_START, 16'($urandom()));
                break;
            end
            if (!clean && $urandom_range(49) == 0)
                offer_cmd(FUNC_UNUSED, 16'($urandom()));
            offer_cmd(FUNC_TICK, speeds[i]);
        end
    endtask

    task automatic run_phase(input int lim, input int n);
        int stop_at;
        stop_at = commands_sent + n;
        while (commands_sent < stop_at)
            run_sequence(lim, 1'b0);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.func      <= FUNC_TICK;
        cmd_ch.fan_speed <= 16'd0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        tx_idle_pct      = 30;
        rx_idle_pct      = 30;
        commands_sent    = 0;
        hold_off_req     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle commands, field extremes, abort mid-run, count carried over
        offer_cmd(FUNC_TICK, 16'd0);
        offer_cmd(FUNC_UNUSED, 16'hFFFF);
        offer_cmd(FUNC_ABORT, 16'h0001);
        offer_cmd(FUNC_START, 16'h0000);
        offer_cmd(FUNC_TICK, 16'hFFFF);
        offer_cmd(FUNC_TICK, 16'h0001);
        offer_cmd(FUNC_TICK, 16'h8000);
        offer_cmd(FUNC_UNUSED, 16'h0000);
        offer_cmd(FUNC_TICK, 16'h0000);
        offer_cmd(FUNC_ABORT, 16'h5555);
        offer_cmd(FUNC_TICK, 16'hAAAA);
        settle();

        // directed at zero tolerance: whole sequence with saturated duty at both ends
        write_limit(8'd0);
        offer_cmd(FUNC_START, 16'hFFFF);
        offer_cmd(FUNC_TICK, 16'd0);
        offer_cmd(FUNC_TICK, 16'd0);
        offer_cmd(FUNC_TICK, 16'd7);
        offer_cmd(FUNC_TICK, 16'd7);
        offer_cmd(FUNC_TICK, 16'd0);
        offer_cmd(FUNC_TICK, 16'd0);
        offer_cmd(FUNC_START, 16'd0);
        offer_cmd(FUNC_TICK, 16'h0100);
        offer_cmd(FUNC_ABORT, 16'd0);
        settle();

        // short tolerance, with the result side held off so the block backs up
        write_limit(8'd3);
        hold_off_req = 1'b1;
        run_phase(3, 330);
        settle();

        // widest tolerance, one clean run to completion
        write_limit(8'd255);
        run_sequence(255, 1'b1);
        settle();

        // zero tolerance, back to back on both sides
        write_limit(8'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(0, 250);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        settle();

        random_limit = $urandom_range(1, 20);
        write_limit(8'(random_limit));
        run_phase(random_limit, 250);
        settle();

        write_limit(LIMIT_RESET);
        while (commands_sent < TOTAL_COMMANDS)
            run_sequence(LIMIT_RESET, 1'b0);

        // drain
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (readouts_due == 0);
        repeat (10) @(posedge clk);

        $display("%0d readouts checked over %0d commands, tolerances 0, 3, %0d, 10 and 255",
                 readouts_checked, commands_sent, random_limit);
        $display("%0d start and %0d stop duties recorded, incl. long output stall",
                 starts_recorded, stops_recorded);
        if (mismatches == 0 && readouts_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/fssc_pkg.sv
rtl/core/fssc_ifs.sv
rtl/core/fssc_apb_regs.sv
rtl/core/fssc_step.sv
rtl/core/fan_start_stop_calibrator.sv
sim/fssc_calibration_checker.sv
sim/fan_start_stop_calibrator_tb.sv
